// ===== sv/rgbds_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbds_pkg
// types, register map and pixel averaging helpers for the 4x4 rgb downscaler
// ----------------------------------------------------------------------------
`default_nettype none

package rgbds_pkg;

  localparam int LINE_WIDTH_W = 11;
  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 11'd624;

  // word index of the configuration register
  localparam logic [0:0] REG_LINE_WIDTH = 1'b0;

  typedef enum logic [1:0] {
    PH_ROW0,
    PH_ROW1,
    PH_ROW2,
    PH_ROW3
  } phase_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    rgb_t       px;
    logic [7:0] column;
    logic       row_end;
  } result_t;

  function automatic logic [7:0] avg8(input logic [7:0] x, input logic [7:0] y);
    logic [8:0] s;
    s = {1'b0, x} + {1'b0, y} + 9'd1;
    return s[8:1];
  endfunction

  function automatic rgb_t avg_px(input rgb_t a, input rgb_t c);
    rgb_t o;
    o.r = avg8(a.r, c.r);
    o.g = avg8(a.g, c.g);
    o.b = avg8(a.b, c.b);
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== sv/rgb_block_downscale_4x4.sv =====
// ----------------------------------------------------------------------------
// rgb_block_downscale_4x4
// 4x4 box downscaler for raster rgb pixels, one output pixel per block
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_ready, one pixel item per handshake in raster
//   order; strip_start on an item restarts it as the first pixel of row 0.
//   output channel: out_valid/out_ready, one item per finished 4x4 block,
//   given on the last pixel of each block in the fourth row of a block row.
//   config: apb write to line_width at address 0 while the block is idle.
// timing
//   one pixel per cycle sustained while in_ready is high; the two line stores take one read and one
//   write each cycle, read at accept and written back in the following cycle.
//   a block's last pixel passes stage 1, stage 2 and the output queue before out_valid rises.
// reset
//   rst clears counters, row phase, column partials and the output queue;
//   line_width returns to 624. line store contents are undefined until written.
// stall
//   a 2-entry output queue holds results; in_ready drops only when the queue
//   and the results still in flight would fill it, so input keeps flowing
//   while a result waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_block_downscale_4x4 #(
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        strip_start,
  input  wire logic [7:0]  red_in,
  input  wire logic [7:0]  green_in,
  input  wire logic [7:0]  blue_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [7:0]  red_out,
  output logic      [7:0]  green_out,
  output logic      [7:0]  blue_out,
  output logic      [7:0]  out_column,
  output logic             row_end
);

  import rgbds_pkg::*;

  localparam int AW = $clog2(MAX_LINE_WIDTH);
  localparam int CAP_RAW = (MAX_LINE_WIDTH / 4) * 4;
  localparam int CAP = (CAP_RAW < 4) ? 4 : CAP_RAW;
  localparam int CW = $clog2(CAP + 1);
  localparam int EW = (CW > LINE_WIDTH_W) ? CW : LINE_WIDTH_W;

  // configuration
  logic [LINE_WIDTH_W-1:0] line_width;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_LINE_WIDTH) begin
      line_width <= pwdata[LINE_WIDTH_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_LINE_WIDTH) begin
      prdata = 32'(line_width);
    end
  end

  // effective width
  logic [EW-1:0] lw_ext;
  logic [EW-1:0] eff_width;

  assign lw_ext = EW'({line_width[LINE_WIDTH_W-1:2], 2'b00});
  assign eff_width = (lw_ext < EW'(4)) ? EW'(4) :
                     (lw_ext > EW'(CAP)) ? EW'(CAP) : lw_ext;

  // stage 0: accept, position, memory read
  logic [AW-1:0] column_count;
  phase_t        row_phase;
  logic [AW-1:0] col;
  phase_t        phase;
  logic          last;
  logic          in_fire;
  rgb_t          px_in;

  assign in_fire = in_valid && in_ready;
  assign col = strip_start ? '0 : column_count;
  assign phase = strip_start ? PH_ROW0 : row_phase;
  assign last = EW'(col) >= (eff_width - EW'(1));
  assign px_in = '{r: red_in, g: green_in, b: blue_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_phase    <= PH_ROW0;
    end else if (in_fire) begin
      if (last) begin
        column_count <= '0;
        row_phase    <= phase_t'(2'(phase + 2'd1));
      end else begin
        column_count <= AW'(col + 1'b1);
        row_phase    <= phase;
      end
    end
  end

  // line stores
  rgb_t first_mem  [MAX_LINE_WIDTH];
  rgb_t second_mem [MAX_LINE_WIDTH];
  rgb_t first_rd;
  rgb_t second_rd;
  rgb_t first_fwd;
  rgb_t second_fwd;
  logic first_fwd_hit;
  logic second_fwd_hit;

  logic          s1_valid;
  logic [AW-1:0] s1_col;
  phase_t        s1_phase;
  logic          s1_last;
  rgb_t          s1_px;

  logic first_we;
  logic second_we;
  rgb_t first_wd;
  rgb_t s1_first;
  rgb_t s1_second;
  rgb_t s1_v;

  always_ff @(posedge clk) begin
    if (first_we) begin
      first_mem[s1_col] <= first_wd;
    end
    if (in_fire) begin
      first_rd <= first_mem[col];
    end
  end

  always_ff @(posedge clk) begin
    if (second_we) begin
      second_mem[s1_col] <= s1_px;
    end
    if (in_fire) begin
      second_rd <= second_mem[col];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_fwd_hit  <= 1'b0;
      second_fwd_hit <= 1'b0;
    end else if (in_fire) begin
      first_fwd_hit  <= first_we && (s1_col == col);
      second_fwd_hit <= second_we && (s1_col == col);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      first_fwd  <= first_wd;
      second_fwd <= s1_px;
    end
  end

  // stage 1: read-modify-write
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_col   <= col;
      s1_phase <= phase;
      s1_last  <= last;
      s1_px    <= px_in;
    end
  end

  assign s1_first  = first_fwd_hit ? first_fwd : first_rd;
  assign s1_second = second_fwd_hit ? second_fwd : second_rd;
  assign s1_v      = avg_px(s1_first, avg_px(s1_second, s1_px));

  assign first_we  = s1_valid && (s1_phase == PH_ROW0 || s1_phase == PH_ROW2);
  assign second_we = s1_valid && (s1_phase == PH_ROW1);
  assign first_wd  = (s1_phase == PH_ROW0) ? s1_px : avg_px(s1_first, s1_px);

  logic s1_res;
  assign s1_res = s1_valid && (s1_phase == PH_ROW3) && (s1_col[1:0] == 2'd3);

  rgb_t partials [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      partials[0] <= '0;
      partials[1] <= '0;
      partials[2] <= '0;
    end else if (s1_valid && s1_phase == PH_ROW3 && s1_col[1:0] != 2'd3) begin
      partials[s1_col[1:0]] <= s1_v;
    end
  end

  // stage 2: horizontal reduction
  logic          s2_valid;
  rgb_t          s2_c02;
  rgb_t          s2_p1;
  rgb_t          s2_v;
  logic [AW-1:0] s2_col;
  logic          s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_res;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_res) begin
      s2_c02  <= avg_px(partials[0], partials[2]);
      s2_p1   <= partials[1];
      s2_v    <= s1_v;
      s2_col  <= s1_col;
      s2_last <= s1_last;
    end
  end

  rgb_t        s2_c13;
  logic [8:0]  blue_sum;
  logic [31:0] s2_col_ext;
  result_t     s2_result;

  assign s2_c13     = avg_px(s2_p1, s2_v);
  assign blue_sum   = {1'b0, s2_c02.b} + {1'b0, s2_c13.b} + 9'(s2_c02.b > s2_c13.b);
  assign s2_col_ext = 32'(s2_col);

  always_comb begin
    s2_result.px.r    = avg8(s2_c02.r, s2_c13.r);
    s2_result.px.g    = avg8(s2_c02.g, s2_c13.g);
    s2_result.px.b    = blue_sum[8:1];
    s2_result.column  = s2_col_ext[9:2];
    s2_result.row_end = s2_last;
  end

  // output queue
  result_t    out_q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       push;
  logic       pop;
  logic [2:0] pending;

  assign push = s2_valid;
  assign pop  = out_valid && out_ready;
  assign pending = 3'(cnt) + 3'(s1_res) + 3'(s2_valid);
  assign in_ready = pending <= 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= 2'(cnt + 2'(push) - 2'(pop));
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_q[wr_ptr] <= s2_result;
    end
  end

  assign out_valid  = cnt != 2'd0;
  assign red_out    = out_q[rd_ptr].px.r;
  assign green_out  = out_q[rd_ptr].px.g;
  assign blue_out   = out_q[rd_ptr].px.b;
  assign out_column = out_q[rd_ptr].column;
  assign row_end    = out_q[rd_ptr].row_end;

`ifndef SYNTHESIS
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && cnt == 2'd2 && !pop))
    else $error("output queue overflow");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= 2'd2)
    else $error("output queue count out of range");

  a_accept_to_s1: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> s1_valid)
    else $error("accepted item did not reach the read-modify-write stage");

  a_result_to_s2: assert property (@(posedge clk) disable iff (rst)
    s1_res |=> s2_valid)
    else $error("block result lost between stages");

  a_single_store_write: assert property (@(posedge clk) disable iff (rst)
    !(first_we && second_we))
    else $error("both line stores written by one item");
`endif

endmodule

`default_nettype wire

// ===== tb/rgbds_block_checker.sv =====
// ----------------------------------------------------------------------------
// rgbds_block_checker
// watches the pixel, block and register channels of the 4x4 rgb downscaler,
// folds every accepted pixel into its own model of the line stores and
// compares each delivered block average, field by field, in arrival order
// ----------------------------------------------------------------------------
module rgbds_block_checker #(
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              strip_start,
  input  logic [7:0]        red_in,
  input  logic [7:0]        green_in,
  input  logic [7:0]        blue_in,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [7:0]        red_out,
  input  logic [7:0]        green_out,
  input  logic [7:0]        blue_out,
  input  logic [7:0]        out_column,
  input  logic              row_end,
  output int unsigned       fail_count,
  output int unsigned       pending,
  output int unsigned       checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import rgbds_pkg::*;

  localparam int unsigned WIDTH_CAP =
    ((MAX_LINE_WIDTH & ~3) < 4) ? 4 : (MAX_LINE_WIDTH & ~3);
  localparam logic [2:0] LINE_WIDTH_ADDR = 3'(REG_LINE_WIDTH) << 2;

  logic [LINE_WIDTH_W-1:0] line_width;
  rgb_t                    row0_line [MAX_LINE_WIDTH];
  rgb_t                    row1_line [MAX_LINE_WIDTH];
  rgb_t                    lane_vals [3];
  int unsigned             col_count;
  phase_t                  row_phase;
  result_t                 block_avg_q [$];

  function automatic logic [7:0] mean8(input logic [7:0] x, input logic [7:0] y);
    logic [8:0] total;
    total = x + y + 9'd1;
    return total[8:1];
  endfunction

  function automatic rgb_t mean_px(input rgb_t a, input rgb_t c);
    rgb_t m;
    m.r = mean8(a.r, c.r);
    m.g = mean8(a.g, c.g);
    m.b = mean8(a.b, c.b);
    return m;
  endfunction

  task automatic fold_pixel(input logic restart, input rgb_t px);
    int unsigned span;
    int unsigned col;
    logic        last;
    rgb_t        vert;
    rgb_t        c02;
    rgb_t        c13;
    result_t     res;
    logic [8:0]  bsum;
    if (restart) begin
      col_count = 0;
      row_phase = PH_ROW0;
    end
    span = line_width & 11'h7FC;
    if (span < 4) span = 4;
    if (span > WIDTH_CAP) span = WIDTH_CAP;
    col = col_count;
    if (col >= MAX_LINE_WIDTH) col = 0;
    last = (col >= span - 1);
    case (row_phase)
      PH_ROW0: row0_line[col] = px;
      PH_ROW1: row1_line[col] = px;
      PH_ROW2: row0_line[col] = mean_px(row0_line[col], px);
      default: begin
        vert = mean_px(row0_line[col], mean_px(row1_line[col], px));
        if (col[1:0] != 2'd3) begin
          lane_vals[col[1:0]] = vert;
        end else begin
          c02 = mean_px(lane_vals[0], lane_vals[2]);
          c13 = mean_px(lane_vals[1], vert);
          // blue leans toward the first column pair
          bsum = {1'b0, c02.b} + {1'b0, c13.b} + {8'd0, c02.b > c13.b};
          res.px.r = mean8(c02.r, c13.r);
          res.px.g = mean8(c02.g, c13.g);
          res.px.b = bsum[8:1];
          res.column = col[9:2];
          res.row_end = last;
          block_avg_q.push_back(res);
        end
      end
    endcase
    if (last) begin
      col_count = 0;
      row_phase = row_phase.next();
    end else begin
      col_count = col + 1;
    end
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      line_width = LINE_WIDTH_RESET;
      foreach (row0_line[i]) row0_line[i] = '0;
      foreach (row1_line[i]) row1_line[i] = '0;
      foreach (lane_vals[i]) lane_vals[i] = '0;
      col_count = 0;
      row_phase = PH_ROW0;
      block_avg_q.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (block_avg_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected block item r %0d g %0d b %0d col %0d end %0b",
                   $time, red_out, green_out, blue_out, out_column, row_end);
        end else begin
          want = block_avg_q.pop_front();
          checked++;
          check_field("red_out", want.px.r, red_out);
          check_field("green_out", want.px.g, green_out);
          check_field("blue_out", want.px.b, blue_out);
          check_field("out_column", want.column, out_column);
          check_field("row_end", want.row_end, row_end);
        end
      end
      if (psel && penable && pwrite && pready && paddr == LINE_WIDTH_ADDR)
        line_width = pwdata[LINE_WIDTH_W-1:0];
      if (in_valid && in_ready)
        fold_pixel(strip_start, '{r: red_in, g: green_in, b: blue_in});
    end
    pending = block_avg_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives raster pixels through the 4x4 rgb downscaler over a series of line
// widths, with random gaps on both channels, a long output stall and strip
// restarts; the block checker predicts and compares, this module gives the
// verdict
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rgbds_pkg::*;

  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int NUM_SEGS = 9;
  localparam logic [2:0] LINE_WIDTH_ADDR = 3'(REG_LINE_WIDTH) << 2;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic        strip_start;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic [7:0]  out_column;
  logic        row_end;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned sent;
  int unsigned cycle_count;
  bit          burst;
  bit          sink_hold;

  // widths below the last one shrink mid-row, the others restart the strip
  int unsigned seg_width [NUM_SEGS] = '{8, 16, 7, 1024, 12, 64, 5, 1023, 20};
  int unsigned seg_items [NUM_SEGS] = '{160, 200, 150, 50, 200, 400, 100, 20, 170};

  rgb_block_downscale_4x4 dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .strip_start(strip_start),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
    .out_column(out_column), .row_end(row_end)
  );

  rgbds_block_checker block_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .strip_start(strip_start),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
    .out_column(out_column), .row_end(row_end),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_pixel(input logic restart, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    strip_start <= restart;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
  endtask

  initial begin : sink
    int unsigned gap;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      gap = burst ? 0 : $urandom_range(0, 9);
      if (sink_hold) begin
        gap = HOLD_CYCLES;
        sink_hold = 1'b0;
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d block items outstanding", cycle_count, pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int          r;
    int          c;
    int unsigned n;
    int unsigned span;
    int unsigned prev_span;
    logic        restart;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    strip_start = 1'b0;
    red_in = '0;
    green_in = '0;
    blue_in = '0;
    burst = 1'b0;
    sink_hold = 1'b0;
    sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // narrowest width; one row and part of the next, then a restart and one full block
    reg_write(LINE_WIDTH_ADDR, 32'd4);
    for (c = 0; c < 5; c++) send_pixel(1'b0, 8'hFF, 8'h00, 8'(c * 60));
    for (r = 0; r < 4; r++) begin
      for (c = 0; c < 4; c++) begin
        send_pixel(r == 0 && c == 0, c[0] ? 8'h00 : 8'hFF, r[0] ? 8'hFF : 8'h00,
                   c[0] ? 8'hFF : 8'h00);
      end
    end
    in_valid <= 1'b0;
    prev_span = 4;

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      wait (pending == 0);
      repeat (SETTLE) @(negedge clk);
      reg_write(LINE_WIDTH_ADDR, seg_width[seg]);
      span = seg_width[seg] & 32'h7FC;
      if (span < 4) span = 4;
      // a wider line needs fresh row 0 and 1 data, so restart the strip
      restart = span > prev_span;
      prev_span = span;
      if (seg == 0) sink_hold = 1'b1;
      for (n = 0; n < seg_items[seg]; n++) begin
        if (n % 64 == 0) burst = (seg == 0 && n < 128) || ($urandom_range(0, 3) == 0);
        send_pixel(restart || $urandom_range(0, 149) == 0, pick_level(), pick_level(),
                   pick_level());
        restart = 1'b0;
      end
      in_valid <= 1'b0;
    end
    burst = 1'b0;

    wait (pending == 0);
    repeat (SETTLE) @(negedge clk);
    $display("sent %0d pixels over %0d line width settings", sent, NUM_SEGS + 1);
    $display("compared %0d block averages, including a long output stall", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
